// ----- sv/nnps_pkg.sv -----
// ----------------------------------------------------------------------------
// nnps_pkg: shared types and constants of the nearest-neighbor pixel scaler
// Holds defaults, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package nnps_pkg;

	localparam int COORD_BITS_DEF       = 12;
	localparam int FRAC_BITS_DEF        = 16;
	localparam int MAX_RUN_DEF          = 8;
	localparam int WHOLE_FACTOR_MAX_DEF = 4;

	localparam int PIX_BITS = 16;
	localparam int CFG_IDX_BITS = 2;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_HEIGHT = 2'd3;

	// register reset values
	localparam int SOURCE_WIDTH_RST  = 256;
	localparam int SOURCE_HEIGHT_RST = 224;
	localparam int TARGET_WIDTH_RST  = 512;
	localparam int TARGET_HEIGHT_RST = 448;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_FRAME,
		ST_FACTOR,
		ST_DIVC_GO,
		ST_DIVC_WAIT,
		ST_DIVR_GO,
		ST_DIVR_WAIT,
		ST_ROW_INIT,
		ST_ROW_WALK,
		ST_COL_INIT,
		ST_COL_WALK,
		ST_EMIT_INIT,
		ST_EMIT,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic frame_init;
		logic factor_step;
		logic div_start;
		logic div_sel_row;
		logic latch_col_step;
		logic latch_row_step;
		logic row_init;
		logic row_walk;
		logic col_init;
		logic col_walk;
		logic emit_init;
		logic emit;
		logic advance;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic frame;
		logic col_zero;
		logic whole;
		logic factor_last;
		logic div_busy;
		logic row_go;
		logic col_go;
		logic empty;
		logic emit_last;
		logic out_free;
	} dp_status_t;

	// RGB565 to A1R5G5B5: alpha set, green drops its low bit
	function automatic logic [PIX_BITS-1:0] to_a1r5g5b5(input logic [PIX_BITS-1:0] p);
		return {1'b1, p[15:6], p[4:0]};
	endfunction

endpackage

// ----- sv/nnps_div.sv -----
// ----------------------------------------------------------------------------
// nnps_div: iterative restoring divider
// One quotient bit per cycle; busy drops when the quotient is complete.
// ----------------------------------------------------------------------------
module nnps_div #(
	parameter int DVD_BITS = 28,
	parameter int DVS_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DVD_BITS-1:0] dividend,
	input  logic [DVS_BITS-1:0] divisor,
	output logic                busy,
	output logic [DVD_BITS-1:0] quotient
);
	localparam int CNT_BITS = $clog2(DVD_BITS + 1);

	logic [DVD_BITS-1:0] quo_q;
	logic [DVS_BITS-1:0] rem_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic [DVS_BITS:0]   trial;
	logic [DVS_BITS:0]   rem_next;
	logic                fits;

	// trial subtract
	always_comb begin
		trial    = {rem_q, quo_q[DVD_BITS-1]};
		fits     = trial >= {1'b0, divisor};
		rem_next = fits ? (trial - {1'b0, divisor}) : trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(DVD_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_BITS-2:0], fits};
			rem_q <= rem_next[DVS_BITS-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ----- sv/nnps_dp.sv -----
// ----------------------------------------------------------------------------
// nnps_dp: scaler datapath
// Config registers, frame/row/column walk state, step divider, output word.
// ----------------------------------------------------------------------------
module nnps_dp #(
	parameter int COORD_BITS       = nnps_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS        = nnps_pkg::FRAC_BITS_DEF,
	parameter int MAX_RUN          = nnps_pkg::MAX_RUN_DEF,
	parameter int WHOLE_FACTOR_MAX = nnps_pkg::WHOLE_FACTOR_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nnps_pkg::dp_cmd_t                 cmd,
	output nnps_pkg::dp_status_t              status,
	input  logic                              cfg_write,
	input  logic [nnps_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]             cfg_data,
	input  logic [nnps_pkg::PIX_BITS-1:0]     pixel_in,
	input  logic                              frame_start,
	input  logic                              result_stall,
	output logic                              result_valid,
	output logic [COORD_BITS-1:0]             dest_column,
	output logic [COORD_BITS-1:0]             dest_row,
	output logic [nnps_pkg::PIX_BITS-1:0]     pixel_out,
	output logic                              run_last
);
	import nnps_pkg::*;

	localparam int ACC_BITS  = COORD_BITS + FRAC_BITS;
	localparam int FW        = $clog2(WHOLE_FACTOR_MAX + 1);
	localparam int PROD_BITS = COORD_BITS + FW;
	localparam int RUN_BITS  = $clog2(MAX_RUN + 1);

	// config registers
	logic [COORD_BITS-1:0] source_width_q, source_height_q;
	logic [COORD_BITS-1:0] target_width_q, target_height_q;

	// walk state
	logic [COORD_BITS-1:0] source_col_q, source_row_q;
	logic [COORD_BITS-1:0] next_dest_col_q, next_dest_row_q;
	logic [ACC_BITS-1:0]   col_acc_q, row_acc_q, col_step_q, row_step_q;
	logic [COORD_BITS-1:0] row_first_q, col_first_q;
	logic [RUN_BITS-1:0]   row_cnt_q, col_cnt_q;
	logic [FW-1:0]         whole_q;
	logic [FW-1:0]         factor_q;
	logic [PROD_BITS-1:0]  mult_w_q, mult_h_q;
	logic [RUN_BITS-1:0]   r_q, c_q;
	logic                  frame_q;
	logic [PIX_BITS-1:0]   pix_q;

	// output word
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] out_col_q, out_row_q;
	logic [PIX_BITS-1:0]   out_pix_q;
	logic                  out_last_q;

	logic [ACC_BITS-1:0]   div_dividend, div_quotient;
	logic [COORD_BITS-1:0] div_divisor;
	logic                  div_busy;

	logic [PROD_BITS-1:0]  row_first_full, col_first_full;
	logic [RUN_BITS-1:0]   wrow_cnt, wcol_cnt;
	logic                  factor_match;
	logic [COORD_BITS-1:0] row_idx, col_idx;
	logic                  row_go, col_go;
	logic                  out_free;
	logic                  emit_last;
	logic                  col_wrap;

	// nearest source index, clamped to the last source pixel
	function automatic logic [COORD_BITS-1:0] src_index(input logic [ACC_BITS-1:0] acc,
			input logic [COORD_BITS-1:0] size);
		logic [COORD_BITS-1:0] s;
		logic [COORD_BITS-1:0] last;
		s    = acc[ACC_BITS-1:FRAC_BITS];
		last = (size == '0) ? '0 : size - COORD_BITS'(1);
		return (s >= last) ? last : s;
	endfunction

	// shared step divider
	assign div_dividend = cmd.div_sel_row ? {source_height_q, {FRAC_BITS{1'b0}}}
	                                      : {source_width_q, {FRAC_BITS{1'b0}}};
	assign div_divisor  = cmd.div_sel_row ? target_height_q : target_width_q;

	nnps_div #(
		.DVD_BITS(ACC_BITS),
		.DVS_BITS(COORD_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.busy    (div_busy),
		.quotient(div_quotient)
	);

	// whole-factor test: f*source equals target on both axes
	assign factor_match = (source_width_q != '0) && (source_height_q != '0) &&
	                      (target_width_q != '0) && (target_height_q != '0) &&
	                      (mult_w_q == PROD_BITS'(target_width_q)) &&
	                      (mult_h_q == PROD_BITS'(target_height_q));

	// whole-factor runs
	always_comb begin
		row_first_full = PROD_BITS'(source_row_q) * PROD_BITS'(whole_q);
		col_first_full = PROD_BITS'(source_col_q) * PROD_BITS'(whole_q);
		wrow_cnt = '0;
		wcol_cnt = '0;
		for (int i = 0; i < MAX_RUN; i++) begin
			if ((i < int'(whole_q)) && ((int'(row_first_full) + i) < int'(target_height_q))) begin
				wrow_cnt = wrow_cnt + RUN_BITS'(1);
			end
			if ((i < int'(whole_q)) && ((int'(col_first_full) + i) < int'(target_width_q))) begin
				wcol_cnt = wcol_cnt + RUN_BITS'(1);
			end
		end
	end

	// fixed-point walk conditions
	always_comb begin
		row_idx = src_index(row_acc_q, source_height_q);
		col_idx = src_index(col_acc_q, source_width_q);
		row_go  = (next_dest_row_q < target_height_q) && (row_idx == source_row_q);
		col_go  = (next_dest_col_q < target_width_q) && (col_idx == source_col_q);
	end

	assign out_free  = !out_valid_q || !result_stall;
	assign emit_last = (r_q + RUN_BITS'(1) == row_cnt_q) && (c_q + RUN_BITS'(1) == col_cnt_q);
	assign col_wrap  = ({1'b0, source_col_q} + (COORD_BITS+1)'(1)) >=
	                   ((source_width_q == '0) ? (COORD_BITS+1)'(1) : {1'b0, source_width_q});

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= COORD_BITS'(SOURCE_WIDTH_RST);
			source_height_q <= COORD_BITS'(SOURCE_HEIGHT_RST);
			target_width_q  <= COORD_BITS'(TARGET_WIDTH_RST);
			target_height_q <= COORD_BITS'(TARGET_HEIGHT_RST);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SOURCE_WIDTH:  source_width_q  <= cfg_data;
				REG_SOURCE_HEIGHT: source_height_q <= cfg_data;
				REG_TARGET_WIDTH:  target_width_q  <= cfg_data;
				REG_TARGET_HEIGHT: target_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_col_q    <= '0;
			source_row_q    <= '0;
			next_dest_col_q <= '0;
			next_dest_row_q <= '0;
			col_acc_q       <= '0;
			row_acc_q       <= '0;
			col_step_q      <= '0;
			row_step_q      <= '0;
			row_first_q     <= '0;
			row_cnt_q       <= '0;
			col_first_q     <= '0;
			col_cnt_q       <= '0;
			whole_q         <= '0;
			factor_q        <= '0;
			mult_w_q        <= '0;
			mult_h_q        <= '0;
			r_q             <= '0;
			c_q             <= '0;
			frame_q         <= 1'b0;
		end else begin
			if (cmd.accept) begin
				frame_q <= frame_start;
			end
			// frame restart
			if (cmd.frame_init) begin
				source_col_q    <= '0;
				source_row_q    <= '0;
				next_dest_col_q <= '0;
				next_dest_row_q <= '0;
				col_acc_q       <= '0;
				row_acc_q       <= '0;
				whole_q         <= '0;
				factor_q        <= FW'(1);
				mult_w_q        <= PROD_BITS'(source_width_q);
				mult_h_q        <= PROD_BITS'(source_height_q);
			end
			if (cmd.factor_step) begin
				if (factor_match) begin
					whole_q <= factor_q;
				end
				factor_q <= factor_q + FW'(1);
				mult_w_q <= mult_w_q + PROD_BITS'(source_width_q);
				mult_h_q <= mult_h_q + PROD_BITS'(source_height_q);
			end
			// steps, all ones for a zero target
			if (cmd.latch_col_step) begin
				col_step_q <= (target_width_q == '0) ? '1 : div_quotient;
			end
			if (cmd.latch_row_step) begin
				row_step_q <= (target_height_q == '0) ? '1 : div_quotient;
			end
			// row start
			if (cmd.row_init) begin
				next_dest_col_q <= '0;
				col_acc_q       <= '0;
				if (whole_q != '0) begin
					row_first_q <= row_first_full[COORD_BITS-1:0];
					row_cnt_q   <= wrow_cnt;
				end else begin
					row_first_q <= next_dest_row_q;
					row_cnt_q   <= '0;
				end
			end
			if (cmd.row_walk && row_go) begin
				if (row_cnt_q != RUN_BITS'(MAX_RUN)) begin
					row_cnt_q <= row_cnt_q + RUN_BITS'(1);
				end
				next_dest_row_q <= next_dest_row_q + COORD_BITS'(1);
				row_acc_q       <= row_acc_q + row_step_q;
			end
			// column run
			if (cmd.col_init) begin
				if (whole_q != '0) begin
					col_first_q <= col_first_full[COORD_BITS-1:0];
					col_cnt_q   <= wcol_cnt;
				end else begin
					col_first_q <= next_dest_col_q;
					col_cnt_q   <= '0;
				end
			end
			if (cmd.col_walk && col_go) begin
				if (col_cnt_q != RUN_BITS'(MAX_RUN)) begin
					col_cnt_q <= col_cnt_q + RUN_BITS'(1);
				end
				next_dest_col_q <= next_dest_col_q + COORD_BITS'(1);
				col_acc_q       <= col_acc_q + col_step_q;
			end
			// emit counters, column inner
			if (cmd.emit_init) begin
				r_q <= '0;
				c_q <= '0;
			end
			if (cmd.emit && out_free) begin
				if (c_q + RUN_BITS'(1) == col_cnt_q) begin
					c_q <= '0;
					r_q <= r_q + RUN_BITS'(1);
				end else begin
					c_q <= c_q + RUN_BITS'(1);
				end
			end
			// source position
			if (cmd.advance) begin
				if (col_wrap) begin
					source_col_q <= '0;
					if (source_row_q != '1) begin
						source_row_q <= source_row_q + COORD_BITS'(1);
					end
				end else begin
					source_col_q <= source_col_q + COORD_BITS'(1);
				end
			end
		end
	end

	// pixel holding register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_q <= to_a1r5g5b5(pixel_in);
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (cmd.emit && out_free) begin
			out_col_q  <= col_first_q + COORD_BITS'(c_q);
			out_row_q  <= row_first_q + COORD_BITS'(r_q);
			out_pix_q  <= pix_q;
			out_last_q <= emit_last;
		end
	end

	always_comb begin
		status.frame       = frame_q;
		status.col_zero    = source_col_q == '0;
		status.whole       = whole_q != '0;
		status.factor_last = factor_q == FW'(WHOLE_FACTOR_MAX);
		status.div_busy    = div_busy;
		status.row_go      = row_go;
		status.col_go      = col_go;
		status.empty       = (row_cnt_q == '0) || (col_cnt_q == '0);
		status.emit_last   = emit_last;
		status.out_free    = out_free;
	end

	assign result_valid = out_valid_q;
	assign dest_column  = out_col_q;
	assign dest_row     = out_row_q;
	assign pixel_out    = out_pix_q;
	assign run_last     = out_last_q;

endmodule

// ----- sv/nnps_ctrl.sv -----
// ----------------------------------------------------------------------------
// nnps_ctrl: scaler sequencer
// Steps one pixel through frame setup, row and column walks and emission.
// ----------------------------------------------------------------------------
module nnps_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  nnps_pkg::dp_status_t status,
	output nnps_pkg::dp_cmd_t    cmd
);
	import nnps_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (pixel_valid) state_d = ST_START;
			ST_START: begin
				if (status.frame) state_d = ST_FRAME;
				else if (status.col_zero) state_d = ST_ROW_INIT;
				else state_d = ST_COL_INIT;
			end
			ST_FRAME: state_d = ST_FACTOR;
			ST_FACTOR: if (status.factor_last) state_d = ST_DIVC_GO;
			ST_DIVC_GO: state_d = ST_DIVC_WAIT;
			ST_DIVC_WAIT: if (!status.div_busy) state_d = ST_DIVR_GO;
			ST_DIVR_GO: state_d = ST_DIVR_WAIT;
			ST_DIVR_WAIT: if (!status.div_busy) state_d = ST_ROW_INIT;
			ST_ROW_INIT: state_d = status.whole ? ST_COL_INIT : ST_ROW_WALK;
			ST_ROW_WALK: if (!status.row_go) state_d = ST_COL_INIT;
			ST_COL_INIT: state_d = status.whole ? ST_EMIT_INIT : ST_COL_WALK;
			ST_COL_WALK: if (!status.col_go) state_d = ST_EMIT_INIT;
			ST_EMIT_INIT: state_d = status.empty ? ST_DONE : ST_EMIT;
			ST_EMIT: if (status.out_free && status.emit_last) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		pixel_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				pixel_stall = 1'b0;
				cmd.accept  = pixel_valid;
			end
			ST_FRAME:     cmd.frame_init = 1'b1;
			ST_FACTOR:    cmd.factor_step = 1'b1;
			ST_DIVC_GO:   cmd.div_start = 1'b1;
			ST_DIVC_WAIT: cmd.latch_col_step = !status.div_busy;
			ST_DIVR_GO: begin
				cmd.div_start   = 1'b1;
				cmd.div_sel_row = 1'b1;
			end
			ST_DIVR_WAIT: begin
				cmd.div_sel_row    = 1'b1;
				cmd.latch_row_step = !status.div_busy;
			end
			ST_ROW_INIT:  cmd.row_init = 1'b1;
			ST_ROW_WALK:  cmd.row_walk = 1'b1;
			ST_COL_INIT:  cmd.col_init = 1'b1;
			ST_COL_WALK:  cmd.col_walk = 1'b1;
			ST_EMIT_INIT: cmd.emit_init = 1'b1;
			ST_EMIT:      cmd.emit = 1'b1;
			ST_DONE:      cmd.advance = 1'b1;
			default: ;
		endcase
	end

endmodule

// ----- sv/nearest_neighbor_pixel_scaler_top.sv -----
// Order: after accept the sequencer passes start, row setup (on source column 0 only), column
// setup and emit setup; each fixed-point walk adds its steps (row walk on column 0 only).
// Throughput: one word per cycle while result_stall is low; a pixel holds the block, and no
// new pixel is taken, until its last word is emitted. Frame start adds the factor test and
// both step divides.
// Reset (async, active low) returns registers to defaults and clears all walk state.
// ----------------------------------------------------------------------------
// nearest_neighbor_pixel_scaler_top: nearest-neighbor RGB565 scaler
// Converts each source pixel to A1R5G5B5 and emits it at its destination run.
// ----------------------------------------------------------------------------
module nearest_neighbor_pixel_scaler_top #(
	parameter int COORD_BITS       = nnps_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS        = nnps_pkg::FRAC_BITS_DEF,
	parameter int MAX_RUN          = nnps_pkg::MAX_RUN_DEF,
	parameter int WHOLE_FACTOR_MAX = nnps_pkg::WHOLE_FACTOR_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [nnps_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]             cfg_data,
	input  logic                              pixel_valid,
	output logic                              pixel_stall,
	input  logic [nnps_pkg::PIX_BITS-1:0]     pixel_in,
	input  logic                              frame_start,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [COORD_BITS-1:0]             dest_column,
	output logic [COORD_BITS-1:0]             dest_row,
	output logic [nnps_pkg::PIX_BITS-1:0]     pixel_out,
	output logic                              run_last
);
	import nnps_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer
	nnps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// datapath
	nnps_dp #(
		.COORD_BITS      (COORD_BITS),
		.FRAC_BITS       (FRAC_BITS),
		.MAX_RUN         (MAX_RUN),
		.WHOLE_FACTOR_MAX(WHOLE_FACTOR_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_in    (pixel_in),
		.frame_start (frame_start),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.dest_column (dest_column),
		.dest_row    (dest_row),
		.pixel_out   (pixel_out),
		.run_last    (run_last)
	);

endmodule

// ----- tb/nearest_neighbor_pixel_scaler_top_tb.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_pixel_scaler_top_tb: self-checking bench for the scaler
// Streams RGB565 frames under many scale settings with random gaps and stalls,
// predicts every destination word and compares it field by field.
// ----------------------------------------------------------------------------
module nearest_neighbor_pixel_scaler_top_tb;
	import nnps_pkg::*;

	localparam int  CLK_HALF    = 10;
	localparam int  SETTLE      = 8500;      // longest pair of walks plus margin
	localparam int  CYCLE_LIMIT = 3000000;
	localparam longint ACC_MASK = (64'd1 << 28) - 1;

	typedef struct packed {
		logic [11:0] col;
		logic [11:0] row;
		logic [15:0] pix;
		logic        last;
	} dest_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = REG_SOURCE_WIDTH;
	logic [11:0] cfg_data = '0;
	logic        pixel_valid = 1'b0;
	logic        pixel_stall;
	logic [15:0] pixel_in = '0;
	logic        frame_start = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [11:0] dest_column;
	logic [11:0] dest_row;
	logic [15:0] pixel_out;
	logic        run_last;

	nearest_neighbor_pixel_scaler_top DUT (.*);

	always #CLK_HALF clk = ~clk;

	// expected destination words, oldest first
	dest_word_t pending_words[$];
	int errors = 0;
	int cycles = 0;
	int rand_items = 0;
	bit no_gaps = 0;

	// predictor copy of registers and walk state
	int unsigned src_w, src_h, dst_w, dst_h;
	int unsigned src_col, src_row, nxt_col, nxt_row;
	longint unsigned col_acc, row_acc, col_inc, row_inc;
	int unsigned run_row0, run_rows, factor;

	function automatic longint unsigned step_of(int unsigned s, int unsigned d);
		if (d == 0) return ACC_MASK;
		return ((longint'(s) << 16) / d) & ACC_MASK;
	endfunction

	function automatic int unsigned src_of(longint unsigned acc, int unsigned size);
		longint unsigned s;
		int unsigned lastp;
		s = acc >> 16;
		lastp = (size == 0) ? 0 : size - 1;
		return (s >= lastp) ? lastp : int'(s);
	endfunction

	// predict the words caused by one accepted pixel
	task automatic scale_pixel(input logic [15:0] p, input logic fs);
		int unsigned cols[8];
		int unsigned ncol, first, cnt;
		dest_word_t w;
		ncol = 0;
		if (fs) begin
			src_col = 0; src_row = 0; nxt_col = 0; nxt_row = 0;
			col_acc = 0; row_acc = 0;
			factor = 0;
			if (src_w && src_h && dst_w && dst_h && dst_w % src_w == 0 &&
			    dst_h % src_h == 0 && dst_w / src_w == dst_h / src_h) begin
				factor = dst_w / src_w;
				if (factor > 4) factor = 0;
			end
			col_inc = step_of(src_w, dst_w);
			row_inc = step_of(src_h, dst_h);
		end
		// row run, fixed for the whole source row
		if (src_col == 0) begin
			cnt = 0;
			if (factor != 0) begin
				first = src_row * factor;
				run_row0 = first & 12'hfff;
				for (int i = 0; i < factor && cnt < 8; i++)
					if (first + i < dst_h) cnt++;
			end else begin
				run_row0 = nxt_row;
				while (nxt_row < dst_h && src_of(row_acc, src_h) == src_row) begin
					if (cnt < 8) cnt++;
					nxt_row++;
					row_acc = (row_acc + row_inc) & ACC_MASK;
				end
			end
			run_rows = cnt;
			nxt_col = 0;
			col_acc = 0;
		end
		// column run of this pixel
		if (factor != 0) begin
			first = src_col * factor;
			for (int i = 0; i < factor && ncol < 8; i++)
				if (first + i < dst_w) cols[ncol++] = (first + i) & 12'hfff;
		end else begin
			while (nxt_col < dst_w && src_of(col_acc, src_w) == src_col) begin
				if (ncol < 8) cols[ncol++] = nxt_col;
				nxt_col++;
				col_acc = (col_acc + col_inc) & ACC_MASK;
			end
		end
		for (int r = 0; r < run_rows; r++)
			for (int c = 0; c < ncol; c++) begin
				w.col  = 12'(cols[c]);
				w.row  = 12'(run_row0 + r);
				w.pix  = {1'b1, p[15:6], p[4:0]};
				w.last = (r + 1 == run_rows) && (c + 1 == ncol);
				pending_words.push_back(w);
			end
		if (src_col + 1 >= ((src_w == 0) ? 1 : src_w)) begin
			src_col = 0;
			if (src_row < 4095) src_row++;
		end else begin
			src_col++;
		end
	endtask

	// send one pixel word, then predict its results
	task automatic send_pixel(input logic [15:0] p, input logic fs);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_in <= p;
		frame_start <= fs;
		do @(posedge clk); while (pixel_stall);
		scale_pixel(p, fs);
	endtask

	// let the block go idle so registers may change
	task automatic drain;
		@(negedge clk);
		pixel_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input int unsigned sw, input int unsigned sh,
	                          input int unsigned tw, input int unsigned th);
		drain();
		@(negedge clk); cfg_write <= 1'b1; cfg_index <= REG_SOURCE_WIDTH;  cfg_data <= 12'(sw);
		@(negedge clk); cfg_index <= REG_SOURCE_HEIGHT; cfg_data <= 12'(sh);
		@(negedge clk); cfg_index <= REG_TARGET_WIDTH;  cfg_data <= 12'(tw);
		@(negedge clk); cfg_index <= REG_TARGET_HEIGHT; cfg_data <= 12'(th);
		@(negedge clk); cfg_write <= 1'b0;
		src_w = sw; src_h = sh; dst_w = tw; dst_h = th;
	endtask

	// directed: pixels before any frame start, then default 2x frame
	task automatic test_defaults;
		send_pixel(16'h1234, 1'b0);
		send_pixel(16'hffff, 1'b0);
		send_pixel(16'h0000, 1'b1);
		send_pixel(16'hffff, 1'b0);
		send_pixel(16'h0020, 1'b0);
		send_pixel(16'h8000, 1'b0);
	endtask

	// directed: whole factors 1, 3, 4 and 5 (which falls back to fixed point)
	task automatic test_whole_factors;
		set_config(4, 3, 4, 3);
		send_pixel(16'h07e0, 1'b1);
		send_pixel(16'hf81f, 1'b0);
		set_config(2, 2, 6, 6);
		send_pixel(16'h001f, 1'b1);
		send_pixel(16'h5555, 1'b0);
		set_config(2, 2, 8, 8);
		send_pixel(16'haaaa, 1'b1);
		set_config(2, 1, 10, 5);
		send_pixel(16'h0001, 1'b1);
		send_pixel(16'hfffe, 1'b0);
	endtask

	// directed: downscale, zero registers, truncated runs, largest sizes
	task automatic test_fixed_point_edges;
		set_config(8, 4, 3, 2);
		for (int i = 0; i < 8; i++) send_pixel($urandom, i == 0);
		set_config(3, 2, 0, 5);
		send_pixel(16'h1111, 1'b1);
		send_pixel(16'h2222, 1'b0);
		set_config(0, 0, 3, 3);
		send_pixel(16'h3333, 1'b1);
		send_pixel(16'h4444, 1'b0);
		set_config(1, 1, 20, 20);
		send_pixel(16'h6666, 1'b1);
		set_config(1, 1, 4095, 4095);
		send_pixel(16'hffff, 1'b1);
		set_config(4095, 4095, 1, 1);
		send_pixel(16'h0000, 1'b1);
		send_pixel(16'h7777, 1'b0);
	endtask

	// random frames, mostly complete, some overrun and stray frame marks
	task automatic test_random_frames;
		int unsigned sw, sh, tw, th, f, n;
		while (rand_items < 300) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			sw = $urandom_range(1, 6);
			sh = $urandom_range(1, 6);
			if ($urandom_range(0, 1)) begin
				f = $urandom_range(1, 5);
				tw = sw * f;
				th = sh * f;
			end else begin
				tw = $urandom_range(1, 12);
				th = $urandom_range(1, 12);
			end
			set_config(sw, sh, tw, th);
			n = sw * sh + $urandom_range(0, 3);
			for (int i = 0; i < n; i++) begin
				send_pixel($urandom, i == 0 || $urandom_range(0, 19) == 0);
				rand_items++;
			end
		end
		no_gaps = 0;
	endtask

	// receiver: random stall before each word, some stretches without
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = no_gaps ? 0 : $urandom_range(0, 6);
			if (n > 0) begin
				@(negedge clk);
				result_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	// compare each accepted word with the oldest prediction
	always @(posedge clk) begin
		dest_word_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word col=%0d row=%0d pix=%h last=%b",
					         dest_column, dest_row, pixel_out, run_last);
			end else begin
				e = pending_words.pop_front();
				if (e.col !== dest_column || e.row !== dest_row ||
				    e.pix !== pixel_out || e.last !== run_last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp col=%0d row=%0d pix=%h last=%b, got col=%0d row=%0d pix=%h last=%b",
						         e.col, e.row, e.pix, e.last,
						         dest_column, dest_row, pixel_out, run_last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("nearest_neighbor_pixel_scaler_top verification failed");
			$finish;
		end
	end

	initial begin
		src_w = SOURCE_WIDTH_RST; src_h = SOURCE_HEIGHT_RST;
		dst_w = TARGET_WIDTH_RST; dst_h = TARGET_HEIGHT_RST;
		src_col = 0; src_row = 0; nxt_col = 0; nxt_row = 0;
		col_acc = 0; row_acc = 0; col_inc = 0; row_inc = 0;
		run_row0 = 0; run_rows = 0; factor = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_defaults();
		test_whole_factors();
		test_fixed_point_edges();
		test_random_frames();
		drain();
		if (errors == 0 && pending_words.size() == 0)
			$display("nearest_neighbor_pixel_scaler_top verification clean");
		else
			$display("nearest_neighbor_pixel_scaler_top verification failed");
		$finish;
	end

endmodule
